FILE: sv/hbac_pkg.sv
package hbac_pkg;

  localparam int unsigned CAP_W  = 48;
  localparam int unsigned SIZE_W = 40;
  localparam int unsigned HOUT_W = 10;

  localparam logic [CAP_W-1:0] CAP_MAX       = '1;
  localparam logic [CAP_W-1:0] INIT_CAP_RST  = 48'd1048576;
  localparam logic [CAP_W-1:0] GROW_STEP_RST = 48'd274877906944;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_ALIAS  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNALLOC = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_INIT_CAP  = 2'd0,
    REG_GROW_STEP = 2'd1,
    REG_RSVD_2    = 2'd2,
    REG_RSVD_3    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              off_we;
    logic              size_we;
    logic [CAP_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } tbl_wr_t;

  function automatic logic [CAP_W-1:0] sat49(input logic [CAP_W:0] x);
    return x[CAP_W] ? CAP_MAX : x[CAP_W-1:0];
  endfunction

  function automatic logic [CAP_W-1:0] grow_once(input logic [CAP_W-1:0] cap,
                                                 input logic [CAP_W-1:0] s);
    logic [CAP_W:0] sum;
    logic [CAP_W:0] dbl;
    sum = {1'b0, cap} + {1'b0, s};
    dbl = {cap, 1'b0};
    if (cap > s) begin
      return sat49(sum);
    end else if (cap == '0) begin
      return 48'd1;
    end
    return sat49(dbl);
  endfunction

endpackage

FILE: sv/hbac_req_if.sv
interface hbac_req_if;
  import hbac_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [9:0]        handle_in;
  logic [SIZE_W-1:0] request_bytes;

  modport source (output valid, output op, output handle_in, output request_bytes,
                  input ready);
  modport sink (input valid, input op, input handle_in, input request_bytes,
                output ready);
endinterface

FILE: sv/hbac_rsp_if.sv
interface hbac_rsp_if;
  import hbac_pkg::*;

  logic              valid;
  logic              ready;
  logic [9:0]        handle_out;
  logic [CAP_W-1:0]  byte_offset;
  logic [SIZE_W-1:0] block_bytes;
  logic [1:0]        status;
  logic              did_compact;
  logic              did_grow;
  logic [CAP_W-1:0]  capacity_now;

  modport source (output valid, output handle_out, output byte_offset,
                  output block_bytes, output status, output did_compact,
                  output did_grow, output capacity_now, input ready);
  modport sink (input valid, input handle_out, input byte_offset,
                input block_bytes, input status, input did_compact,
                input did_grow, input capacity_now, output ready);
endinterface

FILE: sv/hbac_cfg_if.sv
interface hbac_cfg_if;
  import hbac_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [CAP_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/hbac_store.sv
module hbac_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                    clk,
  input  logic [AW-1:0]           wr_addr,
  input  hbac_pkg::tbl_wr_t       wr,
  input  logic [AW-1:0]           rd_addr,
  output logic [hbac_pkg::CAP_W-1:0]  rd_off,
  output logic [hbac_pkg::SIZE_W-1:0] rd_size
);
  import hbac_pkg::*;

  logic [CAP_W-1:0]  off_mem  [DEPTH];
  logic [SIZE_W-1:0] size_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.off_we) begin
      off_mem[wr_addr] <= wr.off;
    end
    if (wr.size_we) begin
      size_mem[wr_addr] <= wr.size;
    end
    rd_off  <= off_mem[rd_addr];
    rd_size <= size_mem[rd_addr];
  end
endmodule

FILE: sv/hbac_remu.sv
module hbac_remu (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hbac_pkg::CAP_W-1:0] dividend,
  input  logic [hbac_pkg::CAP_W-1:0] divisor,
  output logic                       done,
  output logic [hbac_pkg::CAP_W-1:0] rem
);
  import hbac_pkg::*;

  localparam int unsigned CW = $clog2(CAP_W);

  logic             active;
  logic [CW-1:0]    cnt;
  logic [CAP_W-1:0] dvd;
  logic [CAP_W-1:0] dsr;
  logic [CAP_W:0]   trial;

  assign trial = {rem, dvd[CAP_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        dvd    <= dividend;
        dsr    <= divisor;
        rem    <= '0;
      end else if (active) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= CAP_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[CAP_W-1:0];
        end
        dvd <= {dvd[CAP_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(CAP_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: sv/handle_bump_allocator_compacting.sv
// Channel | Dir | Handshake    | Payload
// req     | in  | valid/ready  | op, handle_in, request_bytes
// rsp     | out | valid/ready  | handle_out, byte_offset, block_bytes, status,
//         |     |              | did_compact, did_grow, capacity_now
// cfg     | in  | valid/ready  | index, data (0 initial_capacity, 1 grow_step)
//
// Free, an unknown handle and a full table go from S_EXEC straight to S_OUT;
// lookup passes through S_LOOK for the registered read, a fitting allocation
// through S_PLACE. An allocation past capacity sums live sizes in a table walk,
// grows once if they exceed half the capacity, else compacts in a second walk;
// it then doubles while capacity <= step and runs the bit-serial remainder unit.
// Reset clears control state and loads capacity with 1 MiB; table contents are
// undefined until written. A held result does not stall the walk, only the
// hand-over of the next one.
module handle_bump_allocator_compacting #(
  parameter int unsigned MAX_HANDLES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  hbac_req_if.sink   req,
  hbac_rsp_if.source rsp,
  hbac_cfg_if.sink   cfg
);
  import hbac_pkg::*;

  localparam int unsigned HW   = $clog2(MAX_HANDLES);
  localparam int unsigned ACCW = SIZE_W + HW + 1;

  typedef logic [HW-1:0] hidx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_LOOK, S_SUM, S_DECIDE, S_PACK, S_NEED,
    S_GROW, S_REM, S_FIX, S_PLACE, S_OUT
  } state_t;

  state_t            state;
  logic [HW:0]       nh;
  logic [CAP_W-1:0]  bump;
  logic [CAP_W-1:0]  capacity;
  logic [CAP_W-1:0]  grow_step;
  logic [1:0]        op_r;
  logic [9:0]        h_r;
  logic [SIZE_W-1:0] req_r;
  logic [HW:0]       idx;
  logic              pend;
  hidx_t             pend_idx;
  logic [ACCW-1:0]   acc;
  logic [CAP_W-1:0]  need_r;

  logic [9:0]        res_handle;
  logic [CAP_W-1:0]  res_off;
  logic [SIZE_W-1:0] res_size;
  status_t           res_status;
  logic              res_comp;
  logic              res_grow;

  logic              out_valid;
  logic [9:0]        out_handle;
  logic [CAP_W-1:0]  out_off;
  logic [SIZE_W-1:0] out_size;
  logic [1:0]        out_status;
  logic              out_comp;
  logic              out_grow;
  logic [CAP_W-1:0]  out_cap;

  hidx_t             rd_addr;
  hidx_t             wr_addr;
  tbl_wr_t           wr;
  logic [CAP_W-1:0]  rd_off;
  logic [SIZE_W-1:0] rd_size;

  logic [CAP_W-1:0]  step;
  logic [CAP_W-1:0]  need;
  logic              issue;
  logic              h_bad;
  logic              fits;
  logic              rem_start;
  logic              rem_done;
  logic [CAP_W-1:0]  rem;

  assign step      = (grow_step == '0) ? 48'd1 : grow_step;
  assign need      = sat49({1'b0, bump} + {9'b0, req_r});
  assign issue     = idx < nh;
  assign h_bad     = 32'(h_r) >= 32'(nh) || 32'(h_r) >= MAX_HANDLES;
  assign fits      = ({1'b0, bump} + {9'b0, req_r}) <= {1'b0, capacity};
  assign rem_start = (state == S_GROW) && (capacity < need_r) && (capacity > step);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid        = out_valid;
  assign rsp.handle_out   = out_handle;
  assign rsp.byte_offset  = out_off;
  assign rsp.block_bytes  = out_size;
  assign rsp.status       = out_status;
  assign rsp.did_compact  = out_comp;
  assign rsp.did_grow     = out_grow;
  assign rsp.capacity_now = out_cap;

  always_comb begin
    rd_addr    = idx[HW-1:0];
    wr_addr    = pend_idx;
    wr.off_we  = 1'b0;
    wr.size_we = 1'b0;
    wr.off     = 48'(acc);
    wr.size    = '0;
    unique case (state)
      S_EXEC: begin
        rd_addr = hidx_t'(h_r);
        wr_addr = hidx_t'(h_r);
        wr.off  = '0;
        if (op_r == OP_FREE && !h_bad) begin
          wr.off_we  = 1'b1;
          wr.size_we = 1'b1;
        end
      end
      S_PACK: begin
        wr.off_we = pend && (rd_size != '0);
      end
      S_PLACE: begin
        wr_addr    = nh[HW-1:0];
        wr.off_we  = 1'b1;
        wr.size_we = 1'b1;
        wr.off     = bump;
        wr.size    = req_r;
      end
      default: begin
      end
    endcase
  end

  hbac_store #(
    .DEPTH (MAX_HANDLES),
    .AW    (HW)
  ) u_store (
    .clk     (clk),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_off  (rd_off),
    .rd_size (rd_size)
  );

  hbac_remu u_remu (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (need_r - capacity),
    .divisor  (step),
    .done     (rem_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      nh        <= '0;
      bump      <= '0;
      capacity  <= INIT_CAP_RST;
      grow_step <= GROW_STEP_RST;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r       <= req.op;
            h_r        <= req.handle_in;
            req_r      <= req.request_bytes;
            res_handle <= req.handle_in;
            res_off    <= '0;
            res_size   <= '0;
            res_status <= ST_OK;
            res_comp   <= 1'b0;
            res_grow   <= 1'b0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op_r == OP_ALLOC) begin
            if (32'(nh) >= MAX_HANDLES) begin
              res_handle <= '0;
              res_status <= ST_FULL;
              state      <= S_OUT;
            end else if (fits) begin
              state <= S_PLACE;
            end else begin
              idx   <= '0;
              acc   <= '0;
              pend  <= 1'b0;
              state <= S_SUM;
            end
          end else if (h_bad) begin
            res_status <= ST_UNALLOC;
            state      <= S_OUT;
          end else if (op_r == OP_FREE) begin
            state <= S_OUT;
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          res_off  <= rd_off;
          res_size <= rd_size;
          state    <= S_OUT;
        end
        S_SUM: begin
          pend     <= issue;
          pend_idx <= idx[HW-1:0];
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (pend) begin
            acc <= acc + ACCW'(rd_size);
          end
          if (!issue && !pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (64'(acc) > 64'(capacity[CAP_W-1:1])) begin
            capacity <= grow_once(capacity, step);
            res_grow <= 1'b1;
            state    <= S_NEED;
          end else begin
            idx   <= '0;
            acc   <= '0;
            pend  <= 1'b0;
            state <= S_PACK;
          end
        end
        S_PACK: begin
          pend     <= issue;
          pend_idx <= idx[HW-1:0];
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (pend) begin
            acc <= acc + ACCW'(rd_size);
          end
          if (!issue && !pend) begin
            bump     <= (64'(acc) > 64'(CAP_MAX)) ? CAP_MAX : 48'(acc);
            res_comp <= 1'b1;
            state    <= S_NEED;
          end
        end
        S_NEED: begin
          need_r <= need;
          if (need > capacity) begin
            res_grow <= 1'b1;
            state    <= S_GROW;
          end else begin
            state <= S_PLACE;
          end
        end
        S_GROW: begin
          if (capacity < need_r && capacity <= step) begin
            capacity <= grow_once(capacity, step);
          end else if (capacity < need_r) begin
            state <= S_REM;
          end else begin
            state <= S_PLACE;
          end
        end
        S_REM: begin
          if (rem_done) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (rem == '0) begin
            capacity <= need_r;
          end else begin
            capacity <= sat49({1'b0, need_r} + {1'b0, step - rem});
          end
          state <= S_PLACE;
        end
        S_PLACE: begin
          res_handle <= 10'(nh);
          res_off    <= bump;
          res_size   <= req_r;
          bump       <= sat49({1'b0, bump} + {9'b0, req_r});
          nh         <= nh + 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_handle <= res_handle;
            out_off    <= res_off;
            out_size   <= res_size;
            out_status <= res_status;
            out_comp   <= res_comp;
            out_grow   <= res_grow;
            out_cap    <= capacity;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_INIT_CAP: begin
            if (nh == '0) begin
              capacity <= cfg.data;
            end
          end
          REG_GROW_STEP: begin
            grow_step <= cfg.data;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

FILE: sv/hbac_checker.sv
module hbac_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [9:0]                  handle_out,
  input logic [hbac_pkg::CAP_W-1:0]  byte_offset,
  input logic [hbac_pkg::SIZE_W-1:0] block_bytes,
  input logic [1:0]                  status,
  input logic                        did_compact,
  input logic                        did_grow,
  input logic [hbac_pkg::CAP_W-1:0]  capacity_now
);
  import hbac_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(handle_out) && $stable(capacity_now))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item accepted while previous one in progress");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |->
      handle_out == '0 && byte_offset == '0 && block_bytes == '0)
    else $error("full-table result carries payload");

  a_err_no_change: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> !did_compact && !did_grow)
    else $error("failed request reports compaction or growth");

  a_grow_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && did_grow |-> capacity_now != '0)
    else $error("growth left zero capacity");
endmodule

bind handle_bump_allocator_compacting hbac_checker u_hbac_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .handle_out   (rsp.handle_out),
  .byte_offset  (rsp.byte_offset),
  .block_bytes  (rsp.block_bytes),
  .status       (rsp.status),
  .did_compact  (rsp.did_compact),
  .did_grow     (rsp.did_grow),
  .capacity_now (rsp.capacity_now)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hbac_pkg::*;

  localparam int MAX_H = 1024;
  localparam int WATCHDOG = 20000;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic [HOUT_W-1:0] handle;
    logic [CAP_W-1:0]  offset;
    logic [SIZE_W-1:0] nbytes;
    status_t           status;
    logic              compacted;
    logic              grew;
    logic [CAP_W-1:0]  cap;
  } alloc_reply_t;

  logic clk = 1'b0;
  logic rst;

  hbac_req_if req_ch ();
  hbac_rsp_if rsp_ch ();
  hbac_cfg_if cfg_ch ();

  handle_bump_allocator_compacting #(
    .MAX_HANDLES (MAX_H)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #1 clk = ~clk;

  // allocator state as predicted
  logic [CAP_W-1:0]  blk_off  [MAX_H];
  logic [SIZE_W-1:0] blk_size [MAX_H];
  int unsigned       handles_issued;
  logic [CAP_W-1:0]  bump_ptr;
  logic [CAP_W-1:0]  pool_cap;
  logic [CAP_W-1:0]  grow_step;

  alloc_reply_t replies_owed[$];
  alloc_reply_t want;
  int           mismatches = 0;
  int           quiet = 0;
  bit           steady = 1'b0;

  function automatic logic [CAP_W-1:0] clamp48(logic [63:0] x);
    return (x > 64'(CAP_MAX)) ? CAP_MAX : x[CAP_W-1:0];
  endfunction

  function automatic logic [63:0] eff_step();
    return (grow_step == '0) ? 64'd1 : 64'(grow_step);
  endfunction

  function automatic logic [CAP_W-1:0] grown_once(logic [CAP_W-1:0] c);
    logic [63:0] s;
    s = eff_step();
    if (64'(c) > s) return clamp48(64'(c) + s);
    if (c == '0) return 48'd1;
    return clamp48(64'(c) << 1);
  endfunction

  function automatic logic [CAP_W-1:0] grown_to(logic [CAP_W-1:0] c, logic [63:0] need);
    logic [63:0] s;
    logic [63:0] k;
    logic [63:0] cur;
    s = eff_step();
    cur = 64'(c);
    while (cur < need && cur <= s) cur = 64'(grown_once(cur[CAP_W-1:0]));
    if (cur < need) begin
      k = (need - cur + s - 64'd1) / s;
      cur = 64'(clamp48(cur + k * s));
    end
    return cur[CAP_W-1:0];
  endfunction

  function automatic alloc_reply_t allocator_reply(op_t code, logic [HOUT_W-1:0] h,
                                                   logic [SIZE_W-1:0] nbytes);
    alloc_reply_t r;
    logic [63:0]  live;
    logic [63:0]  pos;
    logic [63:0]  need;
    int           i;
    r = '0;
    if (code == OP_ALLOC) begin
      if (handles_issued >= MAX_H) begin
        r.status = ST_FULL;
      end else begin
        if (64'(bump_ptr) + 64'(nbytes) > 64'(pool_cap)) begin
          live = 0;
          for (i = 0; i < handles_issued; i++) live += 64'(blk_size[i]);
          if (live > 64'(pool_cap / 2)) begin
            pool_cap = grown_once(pool_cap);
            r.grew = 1'b1;
          end else begin
            pos = 0;
            for (i = 0; i < handles_issued; i++) begin
              if (blk_size[i] != '0) begin
                blk_off[i] = pos[CAP_W-1:0];
                pos += 64'(blk_size[i]);
              end
            end
            bump_ptr = clamp48(pos);
            r.compacted = 1'b1;
          end
          need = 64'(clamp48(64'(bump_ptr) + 64'(nbytes)));
          if (need > 64'(pool_cap)) begin
            pool_cap = grown_to(pool_cap, need);
            r.grew = 1'b1;
          end
        end
        blk_off[handles_issued] = bump_ptr;
        blk_size[handles_issued] = nbytes;
        r.offset = bump_ptr;
        r.nbytes = nbytes;
        r.handle = handles_issued[HOUT_W-1:0];
        bump_ptr = clamp48(64'(bump_ptr) + 64'(nbytes));
        handles_issued++;
      end
    end else begin
      r.handle = h;
      if (h >= handles_issued) begin
        r.status = ST_UNALLOC;
      end else if (code == OP_FREE) begin
        blk_size[h] = '0;
        blk_off[h] = '0;
      end else begin
        r.offset = blk_off[h];
        r.nbytes = blk_size[h];
      end
    end
    r.cap = pool_cap;
    return r;
  endfunction

  function automatic logic [63:0] rand_upto(logic [63:0] lim);
    return {$urandom, $urandom} % (lim + 64'd1);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_bytes(bit huge);
    logic [63:0] lim;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (huge) return (r < 90) ? SIZE_MAX : SIZE_W'({$urandom, $urandom});
    if (r < 5) return '0;
    if (r < 8) return SIZE_W'({$urandom, $urandom});
    if (r < 12) return SIZE_W'($urandom_range(1, 16));
    lim = 64'(pool_cap / 6);
    if (lim > 64'(SIZE_MAX)) lim = 64'(SIZE_MAX);
    if (lim == 0) lim = 1;
    lim = rand_upto(lim);
    return lim[SIZE_W-1:0];
  endfunction

  function automatic logic [HOUT_W-1:0] pick_handle();
    int unsigned top;
    top = (handles_issued > MAX_H) ? MAX_H : handles_issued;
    if (top > 0 && $urandom_range(0, 9) < 8) return HOUT_W'($urandom_range(0, top - 1));
    return HOUT_W'($urandom_range(0, MAX_H - 1));
  endfunction

  function void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic issue_request(op_t code, logic [HOUT_W-1:0] h, logic [SIZE_W-1:0] nbytes);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= code;
    req_ch.handle_in <= h;
    req_ch.request_bytes <= nbytes;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    replies_owed.push_back(allocator_reply(code, h, nbytes));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (replies_owed.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CAP_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (idx == REG_INIT_CAP) begin
      if (handles_issued == 0) pool_cap = value;
    end else if (idx == REG_GROW_STEP) begin
      grow_step = value;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_mixed(int n, int alloc_pct, bit huge);
    int                k;
    op_t               code;
    int unsigned       r;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 59) == 0) wait_drain();
      r = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < alloc_pct) code = OP_ALLOC;
      else if (r < 4) code = OP_FREE;
      else if (r < 9) code = OP_LOOKUP;
      else code = OP_ALIAS;
      issue_request(code, pick_handle(), pick_bytes(huge));
    end
  endtask

  task automatic test_unallocated();
    write_reg(REG_INIT_CAP, CAP_MAX);
    issue_request(OP_LOOKUP, 10'd0, '0);
    issue_request(OP_FREE, 10'd1023, SIZE_MAX);
    issue_request(OP_ALIAS, 10'd512, '0);
    issue_request(OP_LOOKUP, 10'h155, 40'hAA_AAAA_AAAA);
    issue_request(OP_FREE, 10'h2AA, 40'h55_5555_5555);
    wait_drain();
  endtask

  task automatic test_zero_settings();
    write_reg(REG_INIT_CAP, '0);
    write_reg(REG_GROW_STEP, '0);
    issue_request(OP_ALLOC, 10'd1023, '0);
    issue_request(OP_ALLOC, 10'd0, 40'd3);
    issue_request(OP_LOOKUP, 10'd0, '0);
    issue_request(OP_LOOKUP, 10'd1, '0);
    issue_request(OP_ALLOC, 10'd5, SIZE_MAX);
    issue_request(OP_LOOKUP, 10'd2, '0);
    issue_request(OP_FREE, 10'd1, '0);
    issue_request(OP_FREE, 10'd1, '0);
    issue_request(OP_LOOKUP, 10'd1, '0);
    issue_request(OP_ALLOC, 10'd0, 40'd7);
    issue_request(OP_FREE, 10'd2, '0);
    issue_request(OP_ALLOC, 10'd0, 40'd5);
    issue_request(OP_LOOKUP, 10'd3, '0);
    issue_request(OP_ALIAS, 10'd4, '0);
    issue_request(OP_LOOKUP, 10'd1023, '0);
    // zero-size block away from offset zero, then force a repack
    issue_request(OP_ALLOC, 10'd0, '0);
    issue_request(OP_FREE, 10'd3, '0);
    issue_request(OP_ALLOC, 10'd0, SIZE_MAX);
    issue_request(OP_LOOKUP, 10'd5, '0);
    wait_drain();
  endtask

  task automatic test_fine_growth();
    write_reg(REG_GROW_STEP, 48'd64);
    write_reg(REG_INIT_CAP, 48'd1);
    write_reg(REG_RSVD_2, CAP_MAX);
    run_mixed(500, 35, 1'b0);
    wait_drain();
  endtask

  task automatic test_doubling();
    write_reg(REG_GROW_STEP, CAP_MAX);
    steady = 1'b1;
    run_mixed(300, 40, 1'b0);
    wait_drain();
    steady = 1'b0;
  endtask

  task automatic test_space_exhaustion();
    write_reg(REG_GROW_STEP, 48'h1000_0000_0000);
    run_mixed(300, 90, 1'b1);
    wait_drain();
  endtask

  task automatic test_table_full();
    write_reg(REG_GROW_STEP, 48'd1);
    write_reg(REG_RSVD_3, '0);
    write_reg(REG_INIT_CAP, 48'h8000_0000_0000);
    run_mixed(600, 75, 1'b0);
    run_mixed(150, 90, 1'b0);
    wait_drain();
  endtask

  // result side: random back-pressure
  initial begin
    int unsigned gap;
    rsp_ch.ready = 1'b0;
    do @(negedge clk); while (rst !== 1'b0);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_owed.size() == 0) begin
        $error("result with nothing outstanding, handle_out %0d", rsp_ch.handle_out);
        mismatches++;
      end else begin
        want = replies_owed.pop_front();
        check_field("handle_out", 64'(want.handle), 64'(rsp_ch.handle_out));
        check_field("byte_offset", 64'(want.offset), 64'(rsp_ch.byte_offset));
        check_field("block_bytes", 64'(want.nbytes), 64'(rsp_ch.block_bytes));
        check_field("status", 64'(want.status), 64'(rsp_ch.status));
        check_field("did_compact", 64'(want.compacted), 64'(rsp_ch.did_compact));
        check_field("did_grow", 64'(want.grew), 64'(rsp_ch.did_grow));
        check_field("capacity_now", 64'(want.cap), 64'(rsp_ch.capacity_now));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.handle_in = '0;
    req_ch.request_bytes = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_INIT_CAP;
    cfg_ch.data = '0;
    handles_issued = 0;
    bump_ptr = '0;
    grow_step = GROW_STEP_RST;
    pool_cap = INIT_CAP_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_unallocated();
    test_zero_settings();
    test_fine_growth();
    test_doubling();
    test_space_exhaustion();
    test_table_full();

    wait_drain();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && replies_owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
